FILE: sv/stag_pkg.sv
`default_nettype none

package stag_pkg;

  // Limit on the walk's dimensions and the number of dimensions held.
  localparam int MAX_RANK = 4;
  localparam int DIMS     = 4;
  localparam int LIM_RANK = (MAX_RANK < DIMS) ? MAX_RANK : DIMS;

  localparam int RANK_W   = 3;
  localparam int SIZE_W   = 16;
  localparam int STRIDE_W = 32;
  localparam int BASE_W   = 32;
  localparam int KIND_W   = 2;
  localparam int PROD_W   = SIZE_W + STRIDE_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int OFF_W    = PROD_W + 3;
  localparam int BOFF_W   = OFF_W + 2;
  localparam int ADDR_W   = 48;
  localparam int BYTES_W  = 40;
  localparam int IDX_W    = 8;
  localparam int DATA_W   = 64;

  localparam int QUEUE_DEPTH = 4;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_RANK          = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BASE_OFFSET   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ELEMENT_KIND  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SIZES_PACKED  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_STRIDES_LOW   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_STRIDES_HIGH  = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_STORAGE_LEN   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_STORAGE_START = IDX_W'(7);

  localparam logic [KIND_W-1:0] ELEM_FP32 = KIND_W'(0);

  localparam logic [DATA_W-1:0] SIZES_RESET = 64'h0001_0001_0001_0001;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_BEYOND = 2'd1;
  localparam status_t STATUS_ZERO   = 2'd2;

  typedef logic [DIMS-1:0][SIZE_W-1:0]   idx_vec_t;
  typedef logic [DIMS-1:0][STRIDE_W-1:0] stride_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0]  act_rank;
    idx_vec_t           size;
    stride_vec_t        stride;
    logic [BASE_W-1:0]  base;
    logic               wide_elem;
    logic [BYTES_W-1:0] storage_len;
    logic [ADDR_W-1:0]  storage_start;
  } cfg_t;

  // One classified element, handed from the front to the back.
  typedef struct packed {
    idx_vec_t idx;
    logic     zero;
    logic     last;
  } tok_t;

  function automatic logic [DIMS-1:0] active_mask(input logic [RANK_W-1:0] r);
    logic [DIMS-1:0] m;
    for (int d = 0; d < DIMS; d++) begin
      m[d] = (RANK_W'(d) < r);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/stag_ifs.sv
`default_nettype none

interface stag_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface stag_rsp_if;
  import stag_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic              last;
  status_t           status;

  modport source (output valid, output byte_address, output last, output status,
                  input ready);
  modport sink (input valid, input byte_address, input last, input status,
                output ready);
endinterface

interface stag_cfg_if;
  import stag_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/stag_front.sv
`default_nettype none

module stag_front
  import stag_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  stag_req_if.sink  req,
  input  wire cfg_t cfg,
  output tok_t      tok,
  output logic      tok_valid,
  input  wire logic tok_ready
);

  idx_vec_t        idx;
  idx_vec_t        idx_next;
  idx_vec_t        cur;
  logic [DIMS-1:0] act;
  logic [DIMS-1:0] sat;
  logic [DIMS-1:0] empty;
  logic            zero;
  logic            last;
  logic            acc;

  assign req.ready = tok_ready;
  assign acc       = req.valid && tok_ready;
  assign act       = active_mask(cfg.act_rank);

  // A counter at or past its final value counts as saturated.
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      cur[d]   = req.restart ? '0 : idx[d];
      sat[d]   = ({1'b0, cur[d]} + (SIZE_W+1)'(1)) >= {1'b0, cfg.size[d]};
      empty[d] = act[d] && (cfg.size[d] == '0);
    end
  end

  assign zero = |empty;
  assign last = &(sat | ~act);

  // Ripple the carry from the innermost active dimension outward.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = DIMS - 1; k >= 0; k--) begin
      idx_next[k] = cur[k];
      if (act[k] && carry) begin
        idx_next[k] = sat[k] ? '0 : cur[k] + SIZE_W'(1);
        carry       = sat[k];
      end
    end
    if (zero) begin
      idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (acc) begin
      idx <= idx_next;
    end
  end

  assign tok_valid = req.valid;
  assign tok.idx   = cur;
  assign tok.zero  = zero;
  assign tok.last  = last;

endmodule

`default_nettype wire

FILE: sv/stag_queue.sv
`default_nettype none

module stag_queue
  import stag_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t push_tok,
  input  wire logic push_valid,
  output logic      push_ready,
  output tok_t      pop_tok,
  output logic      pop_valid,
  input  wire logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tok_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/stag_back.sv
`default_nettype none

module stag_back
  import stag_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire tok_t  tok,
  input  wire logic  tok_valid,
  output logic       tok_ready,
  input  wire cfg_t  cfg,
  stag_rsp_if.source rsp
);

  logic                           en;
  logic [DIMS-1:0]                act;

  logic                           v1;
  logic [DIMS-1:0][PROD_W-1:0]    prod;
  logic                           zero1;
  logic                           last1;

  logic                           v2;
  logic [SUM_W-1:0]               sum_lo;
  logic [SUM_W-1:0]               sum_hi;
  logic                           zero2;
  logic                           last2;

  logic                           v3;
  logic [OFF_W-1:0]               off;
  logic                           zero3;
  logic                           last3;

  logic [BOFF_W-1:0]              boff;
  logic [BOFF_W-1:0]              bend;
  logic [ADDR_W-1:0]              addr;
  logic                           beyond;

  // The whole pipeline moves whenever the output register can take a value.
  assign en        = !rsp.valid || rsp.ready;
  assign tok_ready = en;
  assign act       = active_mask(cfg.act_rank);

  // Byte offset of the element and of the byte just past it.
  assign boff   = cfg.wide_elem ? {off, 2'b00} : {1'b0, off, 1'b0};
  assign bend   = boff + (cfg.wide_elem ? BOFF_W'(4) : BOFF_W'(2));
  assign addr   = cfg.storage_start + boff[ADDR_W-1:0];
  assign beyond = bend > BOFF_W'(cfg.storage_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      v1        <= tok_valid;
      v2        <= v1;
      v3        <= v2;
      rsp.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < DIMS; d++) begin
        prod[d] <= act[d] ? PROD_W'(tok.idx[d]) * PROD_W'(cfg.stride[d]) : '0;
      end
      zero1 <= tok.zero;
      last1 <= tok.last;

      sum_lo <= SUM_W'(prod[0]) + SUM_W'(prod[1]);
      sum_hi <= SUM_W'(prod[2]) + SUM_W'(prod[3]);
      zero2  <= zero1;
      last2  <= last1;

      off   <= OFF_W'(sum_lo) + OFF_W'(sum_hi) + OFF_W'(cfg.base);
      zero3 <= zero2;
      last3 <= last2;

      if (zero3) begin
        rsp.byte_address <= '0;
        rsp.last         <= 1'b1;
        rsp.status       <= STATUS_ZERO;
      end else begin
        rsp.byte_address <= addr;
        rsp.last         <= last3;
        rsp.status       <= beyond ? STATUS_BEYOND : STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/strided_tensor_address_generator_core.sv
`default_nettype none

// Channel  Role    Payload                              Accepted when
// req      sink    restart                              req.valid && req.ready
// rsp      source  byte_address, last, status           rsp.valid && rsp.ready
// cfg      sink    index (register number), data        cfg.valid && cfg.ready
//
// One element address is produced per cycle while rsp is not stalled; each item
// passes the queue, then the multiply, two add stages and the output register.
// Reset clears the walk counters, the queue and the pipeline valid bits, and
// loads the registers with rank one, all sizes one and everything else zero.
// Requests keep flowing while a result waits, until the four-entry queue fills.
// The configuration port is always ready and takes one register per cycle.

module strided_tensor_address_generator_core
  import stag_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  stag_req_if.sink  req,
  stag_rsp_if.source rsp,
  stag_cfg_if.sink  cfg
);

  // Configuration registers, laid out as the register map gives them.
  logic [RANK_W-1:0]  rank;
  logic [BASE_W-1:0]  base_offset;
  logic [KIND_W-1:0]  element_kind;
  logic [DATA_W-1:0]  sizes_packed;
  logic [DATA_W-1:0]  strides_low;
  logic [DATA_W-1:0]  strides_high;
  logic [BYTES_W-1:0] storage_len;
  logic [ADDR_W-1:0]  storage_start;

  cfg_t              cfg_s;
  logic [RANK_W-1:0] act_rank;

  tok_t front_tok;
  logic front_valid;
  logic front_ready;
  tok_t back_tok;
  logic back_valid;
  logic back_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank          <= RANK_W'(1);
      base_offset   <= '0;
      element_kind  <= ELEM_FP32;
      sizes_packed  <= SIZES_RESET;
      strides_low   <= '0;
      strides_high  <= '0;
      storage_len   <= '0;
      storage_start <= '0;
    end else if (cfg.valid) begin
      // Writes to an index past the register map are dropped.
      unique case (cfg.index)
        REG_RANK:          rank          <= cfg.data[RANK_W-1:0];
        REG_BASE_OFFSET:   base_offset   <= cfg.data[BASE_W-1:0];
        REG_ELEMENT_KIND:  element_kind  <= cfg.data[KIND_W-1:0];
        REG_SIZES_PACKED:  sizes_packed  <= cfg.data;
        REG_STRIDES_LOW:   strides_low   <= cfg.data;
        REG_STRIDES_HIGH:  strides_high  <= cfg.data;
        REG_STORAGE_LEN:   storage_len   <= cfg.data[BYTES_W-1:0];
        REG_STORAGE_START: storage_start <= cfg.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // A rank above what the design holds saturates at that limit. Rank zero is
  // a scalar view: no dimension is active and the base element repeats.
  assign act_rank = (rank > RANK_W'(LIM_RANK)) ? RANK_W'(LIM_RANK) : rank;

  // Sizes and strides are packed with dimension zero in the low bits, so the
  // packed arrays line up with the register words directly. Every element kind
  // other than float32 is two bytes wide.
  assign cfg_s.act_rank      = act_rank;
  assign cfg_s.size          = sizes_packed;
  assign cfg_s.stride        = {strides_high, strides_low};
  assign cfg_s.base          = base_offset;
  assign cfg_s.wide_elem     = (element_kind == ELEM_FP32);
  assign cfg_s.storage_len   = storage_len;
  assign cfg_s.storage_start = storage_start;

  // The front owns the index counters: it takes a request, applies a restart,
  // flags an empty view and the final element, and steps the counters in the
  // same cycle so the next request can follow at once.
  stag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg_s),
    .tok       (front_tok),
    .tok_valid (front_valid),
    .tok_ready (front_ready)
  );

  // The queue decouples the counter walk from the address arithmetic, so a
  // stall on the result side does not stop requests until it fills.
  stag_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_tok   (front_tok),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_tok    (back_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // The back turns the index snapshot into a byte address: per-dimension
  // products, a two-level sum with the base, then scaling by the element size,
  // the storage start and the bound check into the output register.
  stag_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (back_tok),
    .tok_valid (back_valid),
    .tok_ready (back_ready),
    .cfg       (cfg_s),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
